// ----- sv/sdspi_pkg.sv -----
// Package: phase codes, command frames and field widths for the SD SPI host sequencer.
`timescale 1ns / 1ps
`default_nettype none
package sdspi_pkg;
  localparam int BLOCK_BYTES_DEF = 512;
  localparam int CSD_BYTES_DEF   = 16;
  localparam int WAKE_BYTES_DEF  = 80;
  localparam int FLUSH_BYTES_DEF = 512;

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_BYTE  = 2'd3;

  localparam logic [4:0] PH_IDLE = 5'd0, PH_WAKE = 5'd1, PH_CNOP = 5'd2,
    PH_CFRAME = 5'd3, PH_CPOLL = 5'd4, PH_ECHO = 5'd5, PH_FLUSH = 5'd6,
    PH_TOKEN = 5'd7, PH_CSD = 5'd8, PH_RDATA = 5'd9, PH_RCRC1 = 5'd10,
    PH_RCRC2 = 5'd11, PH_WDELAY = 5'd12, PH_WTOKEN = 5'd13, PH_WDATA = 5'd14,
    PH_WCRC1 = 5'd15, PH_WCRC2 = 5'd16, PH_WRESP = 5'd17, PH_WAIT = 5'd18;

  localparam logic [1:0] OP_NONE = 2'd0, OP_INIT = 2'd1, OP_READ = 2'd2, OP_WRITE = 2'd3;

  localparam logic [3:0] ST_OK = 4'd0, ST_CMD0 = 4'd1, ST_CMD8 = 4'd2, ST_ECHO = 4'd3,
    ST_ACMD41 = 4'd4, ST_CSD = 4'd5, ST_ADDR = 4'd6, ST_REJECT = 4'd7,
    ST_TOKEN = 4'd8, ST_WREJ = 4'd9;

  localparam logic [47:0] FRAME_CMD0  = 48'h400000000095;
  localparam logic [47:0] FRAME_CMD8  = 48'h48000001AA87;
  localparam logic [47:0] FRAME_CMD55 = 48'h770000000065;
  localparam logic [47:0] FRAME_CMD41 = 48'h694000000077;
  localparam logic [47:0] FRAME_CMD9  = 48'h490000000001;
  localparam logic [7:0]  ID_CMD0 = 8'h40, ID_CMD8 = 8'h48, ID_CMD55 = 8'h77,
    ID_CMD41 = 8'h69, ID_CMD9 = 8'h49, ID_CMD17 = 8'h51, ID_CMD24 = 8'h58;
  localparam logic [31:0] ECHO_PATTERN = 32'h000001AA;
  localparam logic [7:0]  IDLE_BYTE = 8'hFF;
  localparam logic [7:0]  START_TOKEN = 8'hFE;

  localparam logic CFG_RESP_TMO  = 1'b0;
  localparam logic CFG_TOKEN_TMO = 1'b1;
endpackage
`default_nettype wire

// ----- sv/sd_card_spi_host_sequencer_unit.sv -----
// Top level: SD card SPI-mode host sequencer, one exchanged byte per word.
// Output: a result word is registered and presented in the cycle after its input word is accepted.
// Throughput: one word per cycle; the output register is a single stage and
// the input is taken whenever that stage is empty or being drained.
// Reset: synchronous active-low rst_n returns to idle, select high, no card,
// timeouts 256 and 4096.
`timescale 1ns / 1ps
`default_nettype none
module sd_card_spi_host_sequencer_unit
  import sdspi_pkg::*;
#(
  parameter int WAKE_BYTES  = WAKE_BYTES_DEF,
  parameter int FLUSH_BYTES = FLUSH_BYTES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // [1:0] command, [33:2] block_address, [41:34] rx_byte, [49:42] write_data
  input  wire  [55:0] in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // [7:0] tx_byte, [8] tx_request, [9] card_select_level, [10] need_write_data,
  // [18:11] read_data, [19] read_valid, [20] done_res, [24:21] status,
  // [56:25] block_count
  output logic [63:0] out_tdata,
  output logic        out_tlast,
  input  wire         cfg_wr_en,
  input  wire         cfg_index,
  input  wire  [15:0] cfg_wdata
);
  localparam int BLOCK_BYTES = BLOCK_BYTES_DEF;
  localparam int CSD_BYTES   = CSD_BYTES_DEF;

  logic [15:0] resp_tmo_r, token_tmo_r;
  logic [4:0]  phase_r, phase_nxt;
  logic [9:0]  bcnt_r, bcnt_nxt;
  logic [15:0] retry_r, retry_nxt;
  logic [16:0] attempt_r, attempt_nxt;
  logic [47:0] frame_r, frame_nxt;
  logic [2:0]  fidx_r, fidx_nxt;
  logic [31:0] echo_r, echo_nxt;
  logic [21:0] size_r, size_nxt;
  logic [31:0] cap_r, cap_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [3:0]  pend_r, pend_nxt;
  logic        cs_r, cs_nxt;

  logic [7:0]  o_tx;
  logic        o_req, o_need, o_rv, o_rl, o_done;
  logic [7:0]  o_rd;
  logic [3:0]  o_st;
  logic [63:0] res_r;
  logic        res_last_r, out_valid_r;

  logic [1:0]  cmd;
  logic [31:0] addr;
  logic [7:0]  rx, wd;
  logic [15:0] rtmo, ttmo;
  logic        take;

  assign cmd  = in_tdata[1:0];
  assign addr = in_tdata[33:2];
  assign rx   = in_tdata[41:34];
  assign wd   = in_tdata[49:42];
  assign rtmo = (resp_tmo_r == 16'd0) ? 16'd1 : resp_tmo_r;
  assign ttmo = (token_tmo_r == 16'd0) ? 16'd1 : token_tmo_r;
  assign in_tready = !out_valid_r || out_tready;
  assign take = in_tvalid && in_tready;

  // Capacity from C_SIZE: (C_SIZE+1)*1024 saturated; with a 22-bit C_SIZE it fits in
  // 32 bits except at the top C_SIZE value, which the saturation guards.
  logic [32:0] cap_calc;
  assign cap_calc = {1'b0, 10'd0, size_r} + 33'd1;

  // Next-state and result logic for one word
  always_comb begin
    logic [7:0] r1;
    logic       do_disp;
    logic [15:0] rc_inc;
    logic [3:0]  fin_st;
    logic        fin;
    phase_nxt = phase_r; bcnt_nxt = bcnt_r; retry_nxt = retry_r;
    attempt_nxt = attempt_r; frame_nxt = frame_r; fidx_nxt = fidx_r;
    echo_nxt = echo_r; size_nxt = size_r; cap_nxt = cap_r; op_nxt = op_r;
    pend_nxt = pend_r; cs_nxt = cs_r;
    o_tx = 8'd0; o_req = 1'b0; o_need = 1'b0; o_rd = 8'd0; o_rv = 1'b0;
    o_rl = 1'b0; o_done = 1'b0; o_st = ST_OK;
    r1 = IDLE_BYTE; do_disp = 1'b0; fin = 1'b0; fin_st = ST_OK;
    rc_inc = retry_r + 16'd1;

    priority if (cmd == CMD_INIT) begin
      op_nxt = OP_INIT; cap_nxt = 32'd0; size_nxt = 22'd0; cs_nxt = 1'b1;
      bcnt_nxt = 10'd1; phase_nxt = PH_WAKE; o_tx = IDLE_BYTE; o_req = 1'b1;
    end else if (cmd == CMD_READ || cmd == CMD_WRITE) begin
      op_nxt = (cmd == CMD_READ) ? OP_READ : OP_WRITE;
      if (addr >= cap_r) begin
        fin = 1'b1; fin_st = ST_ADDR;
      end else begin
        cs_nxt = 1'b0;
        frame_nxt = {(cmd == CMD_READ) ? ID_CMD17 : ID_CMD24, addr, 8'h01};
        phase_nxt = PH_CNOP; o_tx = IDLE_BYTE; o_req = 1'b1;
      end
    end else begin
      unique case (phase_r)
        PH_WAKE: begin
          o_req = 1'b1; o_tx = IDLE_BYTE;
          if (bcnt_r < 10'(WAKE_BYTES)) bcnt_nxt = bcnt_r + 10'd1;
          else begin
            cs_nxt = 1'b0; attempt_nxt = 17'd0; frame_nxt = FRAME_CMD0; phase_nxt = PH_CNOP;
          end
        end
        PH_CNOP: begin
          fidx_nxt = 3'd0; phase_nxt = PH_CFRAME; o_req = 1'b1; o_tx = frame_r[47:40];
        end
        PH_CFRAME: begin
          fidx_nxt = fidx_r + 3'd1; o_req = 1'b1;
          if (fidx_r + 3'd1 < 3'd6) begin
            unique case (fidx_r)
              3'd0:    o_tx = frame_r[39:32];
              3'd1:    o_tx = frame_r[31:24];
              3'd2:    o_tx = frame_r[23:16];
              3'd3:    o_tx = frame_r[15:8];
              default: o_tx = frame_r[7:0];
            endcase
          end else begin
            retry_nxt = 16'd0; phase_nxt = PH_CPOLL; o_tx = IDLE_BYTE;
          end
        end
        PH_CPOLL: begin
          retry_nxt = rc_inc;
          if (!rx[7]) begin
            do_disp = 1'b1; r1 = rx; retry_nxt = retry_r;
          end else if (rc_inc >= rtmo) begin
            do_disp = 1'b1;
          end else begin
            o_req = 1'b1; o_tx = IDLE_BYTE;
          end
        end
        PH_ECHO: begin
          echo_nxt = {echo_r[23:0], rx}; bcnt_nxt = bcnt_r + 10'd1;
          if (bcnt_r + 10'd1 < 10'd4) begin
            o_req = 1'b1; o_tx = IDLE_BYTE;
          end else if ({echo_r[23:0], rx} == ECHO_PATTERN) begin
            attempt_nxt = 17'd0; frame_nxt = FRAME_CMD55; phase_nxt = PH_CNOP;
            o_req = 1'b1; o_tx = IDLE_BYTE;
          end else begin
            fin = 1'b1; fin_st = ST_ECHO;
          end
        end
        PH_FLUSH: begin
          if (bcnt_r < 10'(FLUSH_BYTES)) begin
            bcnt_nxt = bcnt_r + 10'd1; o_req = 1'b1; o_tx = IDLE_BYTE;
          end else begin
            attempt_nxt = attempt_r + 17'd1;
            if (attempt_r + 17'd1 >= {1'b0, rtmo}) begin
              fin = 1'b1; fin_st = ST_ACMD41;
            end else begin
              frame_nxt = FRAME_CMD55; phase_nxt = PH_CNOP; o_req = 1'b1; o_tx = IDLE_BYTE;
            end
          end
        end
        PH_TOKEN: begin
          o_req = 1'b1; o_tx = IDLE_BYTE;
          if (rx == START_TOKEN) begin
            bcnt_nxt = 10'd0; phase_nxt = (op_r == OP_INIT) ? PH_CSD : PH_RDATA;
          end else begin
            retry_nxt = rc_inc;
            if (rc_inc >= ttmo) begin
              pend_nxt = (op_r == OP_INIT) ? ST_CSD : ST_TOKEN; phase_nxt = PH_WAIT;
            end
          end
        end
        PH_CSD: begin
          if (bcnt_r == 10'd7) size_nxt[21:16] = rx[5:0];
          else if (bcnt_r == 10'd8) size_nxt[15:8] = rx;
          else if (bcnt_r == 10'd9) size_nxt[7:0] = rx;
          bcnt_nxt = bcnt_r + 10'd1; o_req = 1'b1; o_tx = IDLE_BYTE;
          if (bcnt_r + 10'd1 >= 10'(CSD_BYTES)) begin
            pend_nxt = ST_OK; phase_nxt = PH_WAIT;
          end
        end
        PH_RDATA: begin
          o_rd = rx; o_rv = 1'b1; o_req = 1'b1; o_tx = IDLE_BYTE;
          bcnt_nxt = bcnt_r + 10'd1;
          if ({1'b0, bcnt_r} + 11'd1 >= 11'(BLOCK_BYTES)) begin
            o_rl = 1'b1; phase_nxt = PH_RCRC1;
          end
        end
        PH_RCRC1: begin
          phase_nxt = PH_RCRC2; o_req = 1'b1; o_tx = IDLE_BYTE;
        end
        PH_RCRC2: begin
          pend_nxt = ST_OK; phase_nxt = PH_WAIT; o_req = 1'b1; o_tx = IDLE_BYTE;
        end
        PH_WDELAY: begin
          phase_nxt = PH_WTOKEN; o_req = 1'b1; o_tx = START_TOKEN; o_need = 1'b1;
        end
        PH_WTOKEN: begin
          o_req = 1'b1; o_tx = wd; bcnt_nxt = 10'd1; phase_nxt = PH_WDATA;
          o_need = (11'd1 < 11'(BLOCK_BYTES));
        end
        PH_WDATA: begin
          o_req = 1'b1;
          if ({1'b0, bcnt_r} < 11'(BLOCK_BYTES)) begin
            o_tx = wd; bcnt_nxt = bcnt_r + 10'd1;
            o_need = ({1'b0, bcnt_r} + 11'd1 < 11'(BLOCK_BYTES));
          end else begin
            phase_nxt = PH_WCRC1; o_tx = IDLE_BYTE;
          end
        end
        PH_WCRC1: begin
          phase_nxt = PH_WCRC2; o_req = 1'b1; o_tx = IDLE_BYTE;
        end
        PH_WCRC2: begin
          retry_nxt = 16'd0; phase_nxt = PH_WRESP; o_req = 1'b1; o_tx = IDLE_BYTE;
        end
        PH_WRESP: begin
          o_req = 1'b1; o_tx = IDLE_BYTE;
          if (!rx[4]) begin
            pend_nxt = (rx[3:0] == 4'h5) ? ST_OK : ST_WREJ; phase_nxt = PH_WAIT;
          end else begin
            retry_nxt = rc_inc;
            if (rc_inc >= rtmo) begin
              pend_nxt = ST_WREJ; phase_nxt = PH_WAIT;
            end
          end
        end
        PH_WAIT: begin
          if (rx == IDLE_BYTE) begin
            fin = 1'b1; fin_st = pend_r;
          end else begin
            o_req = 1'b1; o_tx = IDLE_BYTE;
          end
        end
        default: ;
      endcase

      // R1 dispatch by command id
      if (do_disp) begin
        unique case (frame_r[47:40])
          ID_CMD0, ID_CMD8: begin
            if (r1 == 8'h01) begin
              if (frame_r[47:40] == ID_CMD0) begin
                attempt_nxt = 17'd0; frame_nxt = FRAME_CMD8; phase_nxt = PH_CNOP;
              end else begin
                bcnt_nxt = 10'd0; echo_nxt = 32'd0; phase_nxt = PH_ECHO;
              end
              o_req = 1'b1; o_tx = IDLE_BYTE;
            end else if (attempt_r > {1'b0, rtmo}) begin
              fin = 1'b1; fin_st = (frame_r[47:40] == ID_CMD0) ? ST_CMD0 : ST_CMD8;
            end else begin
              attempt_nxt = attempt_r + 17'd1; phase_nxt = PH_CNOP;
              o_req = 1'b1; o_tx = IDLE_BYTE;
            end
          end
          ID_CMD55, ID_CMD41: begin
            o_req = 1'b1; o_tx = IDLE_BYTE;
            if (frame_r[47:40] == ID_CMD55 && r1 == 8'h01) begin
              frame_nxt = FRAME_CMD41; phase_nxt = PH_CNOP;
            end else if (frame_r[47:40] == ID_CMD41 && r1 == 8'h00) begin
              frame_nxt = FRAME_CMD9; phase_nxt = PH_CNOP;
            end else begin
              bcnt_nxt = 10'd1; phase_nxt = PH_FLUSH;
            end
          end
          ID_CMD9, ID_CMD17: begin
            o_req = 1'b1; o_tx = IDLE_BYTE;
            if (r1 == 8'h00) begin
              retry_nxt = 16'd0; phase_nxt = PH_TOKEN;
            end else begin
              pend_nxt = (frame_r[47:40] == ID_CMD9) ? ST_CSD : ST_REJECT;
              phase_nxt = PH_WAIT;
            end
          end
          default: begin
            o_req = 1'b1; o_tx = IDLE_BYTE;
            if (r1 == 8'h00) phase_nxt = PH_WDELAY;
            else begin
              pend_nxt = ST_REJECT; phase_nxt = PH_WAIT;
            end
          end
        endcase
      end
    end

    // Operation end
    if (fin) begin
      if (op_r == OP_INIT && fin_st == ST_OK)
        cap_nxt = cap_calc[22] ? 32'hFFFFFFFF : {cap_calc[21:0], 10'd0};
      o_done = 1'b1; o_st = fin_st; phase_nxt = PH_IDLE; op_nxt = OP_NONE;
    end
  end

  // State and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_tmo_r <= 16'd256; token_tmo_r <= 16'd4096;
      phase_r <= PH_IDLE; bcnt_r <= '0; retry_r <= '0; attempt_r <= '0;
      frame_r <= '0; fidx_r <= '0; echo_r <= '0; size_r <= '0; cap_r <= '0;
      op_r <= OP_NONE; pend_r <= ST_OK; cs_r <= 1'b1; out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_RESP_TMO) resp_tmo_r <= cfg_wdata;
        else token_tmo_r <= cfg_wdata;
      end
      if (take) begin
        phase_r <= phase_nxt; bcnt_r <= bcnt_nxt; retry_r <= retry_nxt;
        attempt_r <= attempt_nxt; frame_r <= frame_nxt; fidx_r <= fidx_nxt;
        echo_r <= echo_nxt; size_r <= size_nxt; cap_r <= cap_nxt;
        op_r <= op_nxt; pend_r <= pend_nxt; cs_r <= cs_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= {7'd0, cap_nxt, o_st, o_done, o_rv, o_rd, o_need, cs_nxt, o_req, o_tx};
      res_last_r <= o_rl;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;
  assign out_tlast  = res_last_r;

`ifndef SYNTHESIS
  a_idle_no_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20] |-> !out_tdata[8]) else $error("done with request");
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[19]) else $error("last without data");
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[20] |-> out_tdata[24:21] == ST_OK) else $error("stray status");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(phase_r)) else $error("phase moved without word");
`endif
endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the SD card SPI host sequencer.
`timescale 1ns / 1ps
module testbench;
  import sdspi_pkg::*;

  // One input word and one result word
  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] addr;
    logic [7:0]  rx;
    logic [7:0]  wd;
  } host_word_t;

  typedef struct {
    logic [7:0]  tx;
    logic        req;
    logic        cs;
    logic        need;
    logic [7:0]  rd;
    logic        rv;
    logic        rl;
    logic        done;
    logic [3:0]  st;
    logic [31:0] cnt;
  } card_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;

  sd_card_spi_host_sequencer_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  host_word_t   word_q[$];
  card_result_t result_q[$];
  int n_gen = 0;
  int n_acc = 0;
  int n_res = 0;
  int n_done = 0;
  int errors = 0;
  logic [15:0] status_seen = '0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  // ---------------- host sequencer predictor ----------------
  logic [4:0]  p_phase;
  logic [9:0]  p_bytes;
  logic [31:0] p_retry, p_tries, p_echo, p_cap;
  logic [21:0] p_csize;
  logic [47:0] p_frame;
  logic [2:0]  p_fidx;
  logic [1:0]  p_op;
  logic [3:0]  p_pend;
  logic        p_cs;
  logic [15:0] p_rsp_tmo, p_tok_tmo;
  card_result_t res;

  function automatic logic [31:0] eff_tmo(logic [15:0] t);
    return (t == 16'd0) ? 32'd1 : {16'd0, t};
  endfunction

  function void emit(logic [7:0] b);
    res.tx = b;
    res.req = 1'b1;
  endfunction

  function void end_op(logic [3:0] st);
    logic [63:0] c;
    if (p_op == OP_INIT && st == ST_OK) begin
      c = (64'(p_csize) + 64'd1) * 64'd1024;
      p_cap = (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
    end
    res.done = 1'b1;
    res.st = st;
    p_phase = PH_IDLE;
    p_op = OP_NONE;
  endfunction

  function void wait_idle(logic [3:0] st);
    p_pend = st;
    p_phase = PH_WAIT;
    emit(IDLE_BYTE);
  endfunction

  function void start_cmd(logic [47:0] frame);
    p_frame = frame;
    p_phase = PH_CNOP;
    emit(IDLE_BYTE);
  endfunction

  function void retry_cmd(logic [47:0] frame, logic [3:0] st);
    if (p_tries > eff_tmo(p_rsp_tmo)) end_op(st);
    else begin
      p_tries++;
      start_cmd(frame);
    end
  endfunction

  function void start_flush();
    p_bytes = 10'd1;
    p_phase = PH_FLUSH;
    emit(IDLE_BYTE);
  endfunction

  function void start_token();
    p_retry = 0;
    p_phase = PH_TOKEN;
    emit(IDLE_BYTE);
  endfunction

  // R1 handling depends on which command is in flight
  function void take_r1(logic [7:0] r1);
    case (p_frame[47:40])
      ID_CMD0: begin
        if (r1 == 8'h01) begin
          p_tries = 0;
          start_cmd(FRAME_CMD8);
        end else retry_cmd(FRAME_CMD0, ST_CMD0);
      end
      ID_CMD8: begin
        if (r1 == 8'h01) begin
          p_bytes = 0;
          p_echo = 0;
          p_phase = PH_ECHO;
          emit(IDLE_BYTE);
        end else retry_cmd(FRAME_CMD8, ST_CMD8);
      end
      ID_CMD55: begin
        if (r1 == 8'h01) start_cmd(FRAME_CMD41);
        else start_flush();
      end
      ID_CMD41: begin
        if (r1 == 8'h00) start_cmd(FRAME_CMD9);
        else start_flush();
      end
      ID_CMD9: begin
        if (r1 == 8'h00) start_token();
        else wait_idle(ST_CSD);
      end
      ID_CMD17: begin
        if (r1 == 8'h00) start_token();
        else wait_idle(ST_REJECT);
      end
      default: begin
        if (r1 == 8'h00) begin
          p_phase = PH_WDELAY;
          emit(IDLE_BYTE);
        end else wait_idle(ST_REJECT);
      end
    endcase
  endfunction

  // One finished byte exchange while an operation runs
  function void exchange(logic [7:0] rx, logic [7:0] wd);
    case (p_phase)
      PH_WAKE: begin
        if (p_bytes < WAKE_BYTES_DEF) begin
          p_bytes++;
          emit(IDLE_BYTE);
        end else begin
          p_cs = 1'b0;
          p_tries = 0;
          start_cmd(FRAME_CMD0);
        end
      end
      PH_CNOP: begin
        p_fidx = 0;
        p_phase = PH_CFRAME;
        emit(p_frame[47:40]);
      end
      PH_CFRAME: begin
        p_fidx = p_fidx + 3'd1;
        if (p_fidx < 3'd6) emit(8'(p_frame >> (8 * (5 - int'(p_fidx)))));
        else begin
          p_retry = 0;
          p_phase = PH_CPOLL;
          emit(IDLE_BYTE);
        end
      end
      PH_CPOLL: begin
        if (!rx[7]) take_r1(rx);
        else begin
          p_retry++;
          if (p_retry >= eff_tmo(p_rsp_tmo)) take_r1(8'hFF);
          else emit(IDLE_BYTE);
        end
      end
      PH_ECHO: begin
        p_echo = {p_echo[23:0], rx};
        p_bytes++;
        if (p_bytes < 10'd4) emit(IDLE_BYTE);
        else if (p_echo == ECHO_PATTERN) begin
          p_tries = 0;
          start_cmd(FRAME_CMD55);
        end else end_op(ST_ECHO);
      end
      PH_FLUSH: begin
        if (p_bytes < FLUSH_BYTES_DEF) begin
          p_bytes++;
          emit(IDLE_BYTE);
        end else begin
          p_tries++;
          if (p_tries >= eff_tmo(p_rsp_tmo)) end_op(ST_ACMD41);
          else start_cmd(FRAME_CMD55);
        end
      end
      PH_TOKEN: begin
        if (rx == START_TOKEN) begin
          p_bytes = 0;
          p_phase = (p_op == OP_INIT) ? PH_CSD : PH_RDATA;
          emit(IDLE_BYTE);
        end else begin
          p_retry++;
          if (p_retry >= eff_tmo(p_tok_tmo)) wait_idle((p_op == OP_INIT) ? ST_CSD : ST_TOKEN);
          else emit(IDLE_BYTE);
        end
      end
      PH_CSD: begin
        // C_SIZE sits in CSD bytes 7..9
        if (p_bytes == 10'd7) p_csize[21:16] = rx[5:0];
        else if (p_bytes == 10'd8) p_csize[15:8] = rx;
        else if (p_bytes == 10'd9) p_csize[7:0] = rx;
        p_bytes++;
        if (p_bytes >= CSD_BYTES_DEF) wait_idle(ST_OK);
        else emit(IDLE_BYTE);
      end
      PH_RDATA: begin
        res.rd = rx;
        res.rv = 1'b1;
        p_bytes++;
        if (p_bytes >= BLOCK_BYTES_DEF) begin
          res.rl = 1'b1;
          p_phase = PH_RCRC1;
        end
        emit(IDLE_BYTE);
      end
      PH_RCRC1: begin
        p_phase = PH_RCRC2;
        emit(IDLE_BYTE);
      end
      PH_RCRC2: wait_idle(ST_OK);
      PH_WDELAY: begin
        p_phase = PH_WTOKEN;
        emit(START_TOKEN);
        res.need = 1'b1;
      end
      PH_WTOKEN: begin
        emit(wd);
        p_bytes = 10'd1;
        p_phase = PH_WDATA;
        res.need = 1'b1;
      end
      PH_WDATA: begin
        if (p_bytes < BLOCK_BYTES_DEF) begin
          emit(wd);
          p_bytes++;
          res.need = (p_bytes < BLOCK_BYTES_DEF);
        end else begin
          p_phase = PH_WCRC1;
          emit(IDLE_BYTE);
        end
      end
      PH_WCRC1: begin
        p_phase = PH_WCRC2;
        emit(IDLE_BYTE);
      end
      PH_WCRC2: begin
        p_retry = 0;
        p_phase = PH_WRESP;
        emit(IDLE_BYTE);
      end
      PH_WRESP: begin
        if (!rx[4]) wait_idle((rx[3:0] == 4'h5) ? ST_OK : ST_WREJ);
        else begin
          p_retry++;
          if (p_retry >= eff_tmo(p_rsp_tmo)) wait_idle(ST_WREJ);
          else emit(IDLE_BYTE);
        end
      end
      PH_WAIT: begin
        if (rx == IDLE_BYTE) end_op(p_pend);
        else emit(IDLE_BYTE);
      end
      default: ;
    endcase
  endfunction

  function card_result_t sd_host_step(host_word_t w);
    res = '{default: '0};
    case (w.cmd)
      CMD_INIT: begin
        p_op = OP_INIT;
        p_cap = 0;
        p_csize = 0;
        p_cs = 1'b1;
        p_bytes = 10'd1;
        p_phase = PH_WAKE;
        emit(IDLE_BYTE);
      end
      CMD_READ, CMD_WRITE: begin
        p_op = (w.cmd == CMD_READ) ? OP_READ : OP_WRITE;
        if (w.addr >= p_cap) end_op(ST_ADDR);
        else begin
          p_cs = 1'b0;
          start_cmd({(w.cmd == CMD_READ) ? ID_CMD17 : ID_CMD24, w.addr, 8'h01});
        end
      end
      default: if (p_phase != PH_IDLE) exchange(w.rx, w.wd);
    endcase
    res.cs = p_cs;
    res.cnt = p_cap;
    return res;
  endfunction

  // ---------------- stimulus helpers ----------------
  task automatic push_word(logic [1:0] cmd, logic [31:0] addr, logic [7:0] rx,
                           logic [7:0] wd);
    host_word_t w;
    w.cmd = cmd;
    w.addr = addr;
    w.rx = rx;
    w.wd = wd;
    word_q.push_back(w);
    result_q.push_back(sd_host_step(w));
    n_gen++;
  endtask

  // Card side reply for the exchange the sequencer is in, mostly well formed
  function automatic logic [7:0] card_reply();
    int r, good;
    r = $urandom_range(0, 99);
    good = (p_rsp_tmo <= 2) ? 50 : (p_rsp_tmo <= 6) ? 75 : 95;
    case (p_phase)
      PH_CPOLL: begin
        if (r < good) begin
          case (p_frame[47:40])
            ID_CMD0, ID_CMD8, ID_CMD55: return 8'h01;
            default: return 8'h00;
          endcase
        end
        if (r < good + (100 - good) * 2 / 3) return {1'b1, 7'($urandom)};
        return {1'b0, 7'($urandom)};
      end
      PH_ECHO: begin
        if (r < 95) return 8'(ECHO_PATTERN >> (8 * (3 - int'(p_bytes))));
        return 8'($urandom);
      end
      PH_TOKEN: begin
        if (r < ((p_tok_tmo <= 2) ? 50 : 90)) return START_TOKEN;
        return 8'($urandom);
      end
      PH_WRESP: begin
        if (r < good) return 8'hE5;
        if (r < good + 5) return 8'hEB;
        return 8'($urandom) | 8'h10;
      end
      PH_WAIT: begin
        if (r < 50) return IDLE_BYTE;
        return 8'($urandom);
      end
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (p_cap == 0 || r < 5) return $urandom;
    if (r < 10) return p_cap - 32'd1;
    if (r < 14) return p_cap;
    return $urandom % p_cap;
  endfunction

  // Random operations with card replies, until n more words are queued
  task automatic random_ops(int n);
    int stop_at, r;
    stop_at = n_gen + n;
    while (n_gen < stop_at) begin
      if (p_phase == PH_IDLE) begin
        r = $urandom_range(0, 5);
        if (p_cap == 0 || r == 0) push_word(CMD_INIT, $urandom, $urandom, $urandom);
        else push_word((r < 3) ? CMD_READ : CMD_WRITE, pick_addr(), $urandom, $urandom);
      end else if ($urandom_range(0, 499) == 0) begin
        // start while busy abandons the operation
        push_word(2'($urandom_range(0, 2)), pick_addr(), $urandom, $urandom);
      end else begin
        push_word(CMD_BYTE, $urandom, card_reply(), $urandom);
      end
    end
  endtask

  task automatic drain();
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(logic idx, logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_RESP_TMO) p_rsp_tmo = val;
    else p_tok_tmo = val;
  endtask

  task automatic set_timeouts(logic [15:0] rsp, logic [15:0] tok);
    drain();
    set_reg(CFG_RESP_TMO, rsp);
    set_reg(CFG_TOKEN_TMO, tok);
  endtask

  // ---------------- sequence ----------------
  initial begin
    p_phase = PH_IDLE; p_bytes = 0; p_retry = 0; p_tries = 0; p_echo = 0;
    p_cap = 0; p_csize = 0; p_frame = 0; p_fidx = 0; p_op = OP_NONE;
    p_pend = 0; p_cs = 1'b1; p_rsp_tmo = 16'd256; p_tok_tmo = 16'd4096;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: no card yet, so reads and writes hit the address check
    push_word(CMD_READ, 32'h0000_0000, 8'h00, 8'h00);
    push_word(CMD_WRITE, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    push_word(CMD_BYTE, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    push_word(CMD_BYTE, 32'h0000_0000, 8'h00, 8'h00);
    push_word(CMD_INIT, 32'h0000_0000, 8'h00, 8'h00);
    push_word(CMD_BYTE, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    push_word(CMD_BYTE, 32'h0000_0000, 8'h00, 8'h00);
    push_word(CMD_READ, 32'h0000_0000, 8'h5A, 8'hA5);
    push_word(CMD_INIT, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    push_word(CMD_WRITE, 32'h0000_0001, 8'h00, 8'h00);
    push_word(CMD_BYTE, 32'h0000_0000, 8'h00, 8'h00);

    // Reset timeouts with a long receiver hold-off partway in, then timeouts of 0, max, 1 and 2..6
    drain();
    hold_req = 1'b1;
    random_ops(400);
    set_timeouts(16'd0, 16'd0);
    random_ops(300);
    set_timeouts(16'hFFFF, 16'hFFFF);
    random_ops(400);
    set_timeouts(16'd1, 16'd1);
    random_ops(300);
    set_timeouts(16'($urandom_range(2, 6)), 16'($urandom_range(2, 6)));
    drain();
    idle_on = 1'b0;
    random_ops(400);
    drain();
    repeat (10) @(posedge clk);

    $display("Run: %0d words in, %0d results checked, %0d operations finished",
             n_acc, n_res, n_done);
    $display("Status codes reached (one bit per code): %b", status_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------- driver ----------------
  int gap_left = 0;
  always @(posedge clk) begin
    host_word_t w;
    if (rst_n) begin
      if (in_tvalid && in_tready) n_acc <= n_acc + 1;
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (word_q.size() != 0) begin
          w = word_q.pop_front();
          in_tdata <= {6'd0, w.wd, w.rx, w.addr, w.cmd};
          in_tvalid <= 1'b1;
          if (idle_on && $urandom_range(0, 15) == 0) gap_left <= $urandom_range(1, 16);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver ready ----------------
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_req && !hold_done && n_acc > 200) begin
        // long hold-off so the block backs up and stalls its input
        hold_done <= 1'b1;
        hold_left <= 400;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
        stall_left <= $urandom_range(0, 15);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------- monitor ----------------
  function automatic void check_field(string nm, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", nm, e, a);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    card_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      n_res++;
      if (result_q.size() == 0) begin
        $error("result word with nothing expected: 0x%0h", out_tdata);
        errors++;
      end else begin
        e = result_q.pop_front();
        check_field("tx_byte", e.tx, out_tdata[7:0]);
        check_field("tx_request", e.req, out_tdata[8]);
        check_field("card_select_level", e.cs, out_tdata[9]);
        check_field("need_write_data", e.need, out_tdata[10]);
        check_field("read_data", e.rd, out_tdata[18:11]);
        check_field("read_valid", e.rv, out_tdata[19]);
        check_field("read_last", e.rl, out_tlast);
        check_field("done_res", e.done, out_tdata[20]);
        check_field("status", e.st, out_tdata[24:21]);
        check_field("block_count", e.cnt, out_tdata[56:25]);
        if (e.done) begin
          n_done++;
          status_seen[e.st] = 1'b1;
        end
      end
    end
  end
endmodule
